// File: rtl/core/dds_pkg.sv
// Shared types and constants of the two-channel wavetable synthesizer.
// No dependencies; used by dds_scale and dual_channel_dds_am_fm.
package dds_pkg;

  // Default sizes
  localparam int WaveDepthDef  = 1024;
  localparam int SweepDepthDef = 512;
  localparam int PhaseWidthDef = 32;

  // Fixed field widths
  localparam int SampleW = 12;
  localparam int StepW   = 32;
  localparam int IndexW  = 10;
  localparam int FlagsW  = 6;
  localparam int CfgIdxW = 3;

  // Output scaling: mid code, 0.65 volume in Q16, full-scale envelope
  localparam int MidCode   = 2048;
  localparam int VolumeQ16 = 42598;
  localparam int EnvFull   = 4095;
  // Bias that lifts the scaled value above zero before the divide by 4095
  localparam int DivOffset = EnvFull * MidCode;
  // floor(2^36 / 4095), good for dividends below 2^24 with one correction
  localparam longint Recip4095 = 64'd16781313;
  localparam int RecipShift = 36;

  // Per-channel flag bit positions
  localparam int FlagEn = 0;
  localparam int FlagAm = 1;
  localparam int FlagFm = 2;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_CARRIER  = 2'd1,
    MODE_ENVELOPE = 2'd2,
    MODE_SWEEP    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLAGS      = 3'd0,
    REG_CH1_CAR    = 3'd1,
    REG_CH1_AM     = 3'd2,
    REG_CH1_FM     = 3'd3,
    REG_CH2_CAR    = 3'd4,
    REG_CH2_AM     = 3'd5,
    REG_CH2_FM     = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_RD,
    ST_TBL_RD,
    ST_CAR_RD,
    ST_MUL,
    ST_P2,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// File: rtl/core/dds_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dds_ram #(
  parameter int Width = 12,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dds_scale.sv
// Output scaling pipeline: 2048 + floor((c-2048)*a*42598 / (4095*65536)).
// Three register stages; result valid combinationally after the third. Uses dds_pkg.
module dds_scale import dds_pkg::*; (
  input  logic               clk_i,
  input  logic [SampleW-1:0] carrier_i,
  input  logic [SampleW-1:0] env_i,
  output logic [SampleW-1:0] sample_o
);

  logic signed [12:0] c_s;
  logic signed [12:0] e_s;
  logic signed [25:0] p1_d, p1_q;
  logic signed [42:0] p2;
  logic [24:0]        tp_d, tp_q, tp2_q;
  logic [49:0]        recip_prod;
  logic [13:0]        q0_d, q0_q;
  logic [25:0]        rem;
  logic [13:0]        q_fix;

  // Stage 1: signed carrier times envelope gain
  assign c_s  = $signed({1'b0, carrier_i}) - 13'(MidCode);
  assign e_s  = $signed({1'b0, env_i});
  assign p1_d = 26'(c_s) * 26'(e_s);

  // Stage 2: volume, floor by 2^16, bias so the dividend is positive
  assign p2   = 43'(p1_q) * 43'(VolumeQ16);
  assign tp_d = 25'(p2[42:16] + 27'(DivOffset));

  // Stage 3: quotient estimate by reciprocal, one short at most
  assign recip_prod = 50'(tp_q) * 50'(Recip4095);
  assign q0_d       = recip_prod[49:RecipShift];

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    tp_q  <= tp_d;
    q0_q  <= q0_d;
    tp2_q <= tp_q;
  end

  // Correction: remainder check; the bias makes the quotient the DAC code
  assign rem      = {1'b0, tp2_q} - (26'(q0_q) << 12) + 26'(q0_q);
  assign q_fix    = (rem >= 26'(EnvFull)) ? q0_q + 14'd1 : q0_q;
  assign sample_o = q_fix[SampleW-1:0];

endmodule

// File: rtl/core/dual_channel_dds_am_fm.sv
// Top level of the two-channel wavetable synthesizer with AM and FM.
// Uses dds_pkg, dds_ram (phase and table memories) and dds_scale.
//
//  channel   | dir | tdata (low bit up)                  | tuser
//  s_axis    | in  | table_index[9:0], table_value[41:10] | mode[1:0], channel[2]
//  m_axis    | out | sample_one[11:0], sample_two[23:12]  | -
//  cfg       | in  | cfg_index_i selects, cfg_data_i value, cfg_we_i strobe
//
// A table write item is taken while the sequencer is idle. An accepted tick runs
// each channel in turn through the phase memory read, table reads, write-back
// and the three-stage scaling pipeline, then loads the output register.
// Reset clears flags, steps and phase-valid bits (phases read as zero).
// Table memories are not cleared. A finished result waits in the output
// register; table writes are still accepted meanwhile.
module dual_channel_dds_am_fm import dds_pkg::*; #(
  parameter int WAVE_DEPTH  = WaveDepthDef,
  parameter int SWEEP_DEPTH = SweepDepthDef,
  parameter int PHASE_WIDTH = PhaseWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // table_index[9:0], table_value[41:10]
  input  logic [2:0]         s_axis_tuser,  // mode[1:0], channel[2]
  // Result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // sample_one[11:0], sample_two[23:12]
  // Configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [StepW-1:0]   cfg_data_i
);

  localparam int PW = PHASE_WIDTH;
  localparam int CW = $clog2(WAVE_DEPTH);
  localparam int SW = $clog2(SWEEP_DEPTH);

  // Table index from a phase: (phase * depth) >> PW
  function automatic logic [CW-1:0] wave_idx(input logic [PW-1:0] ph);
    logic [PW+CW:0] prod;
    prod = (PW+CW+1)'(ph) * (PW+CW+1)'(WAVE_DEPTH);
    return prod[PW +: CW];
  endfunction

  function automatic logic [SW-1:0] sweep_idx(input logic [PW-1:0] ph);
    logic [PW+SW:0] prod;
    prod = (PW+SW+1)'(ph) * (PW+SW+1)'(SWEEP_DEPTH);
    return prod[PW +: SW];
  endfunction

  // Input fields
  logic [IndexW-1:0] tbl_idx;
  logic [StepW-1:0]  tbl_val;
  mode_e             in_mode;
  logic              in_ch;
  logic              in_acc;

  assign tbl_idx = s_axis_tdata[9:0];
  assign tbl_val = s_axis_tdata[41:10];
  assign in_mode = mode_e'(s_axis_tuser[1:0]);
  assign in_ch   = s_axis_tuser[2];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  logic [FlagsW-1:0] flags_q;
  logic [StepW-1:0]  car_step_q [2];
  logic [StepW-1:0]  am_step_q  [2];
  logic [StepW-1:0]  fm_step_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      car_step_q[0] <= '0;
      car_step_q[1] <= '0;
      am_step_q[0]  <= '0;
      am_step_q[1]  <= '0;
      fm_step_q[0]  <= '0;
      fm_step_q[1]  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FLAGS:   flags_q       <= cfg_data_i[FlagsW-1:0];
        REG_CH1_CAR: car_step_q[0] <= cfg_data_i;
        REG_CH1_AM:  am_step_q[0]  <= cfg_data_i;
        REG_CH1_FM:  fm_step_q[0]  <= cfg_data_i;
        REG_CH2_CAR: car_step_q[1] <= cfg_data_i;
        REG_CH2_AM:  am_step_q[1]  <= cfg_data_i;
        REG_CH2_FM:  fm_step_q[1]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e state_q, state_d;
  logic   ch_q, ch_d;
  logic   ch_en, ch_am, ch_fm;

  assign ch_en = flags_q[3*ch_q + FlagEn];
  assign ch_am = flags_q[3*ch_q + FlagAm];
  assign ch_fm = flags_q[3*ch_q + FlagFm];

  // Table memory write side (idle only)
  logic car_we, env_we, swp_we;
  assign car_we = in_acc && (in_mode == MODE_CARRIER)
                  && (32'(tbl_idx) < 32'(WAVE_DEPTH));
  assign env_we = in_acc && (in_mode == MODE_ENVELOPE)
                  && (32'(tbl_idx) < 32'(WAVE_DEPTH));
  assign swp_we = in_acc && (in_mode == MODE_SWEEP)
                  && (32'(tbl_idx) < 32'(SWEEP_DEPTH));

  // Phase memory and working registers
  logic            ph_re, ph_we;
  logic [3*PW-1:0] ph_rdata, ph_wdata;
  logic [1:0]      ph_vld_q;
  logic [PW-1:0]   car_ph, env_ph, sw_ph;
  logic [PW-1:0]   sw_new, env_new, car_new;
  logic [PW-1:0]   car_old_q, env_q, sw_q;
  logic [SampleW-1:0] gain_d, gain_q;

  logic [SampleW-1:0] car_rdata, env_rdata, scaled;
  logic [StepW-1:0]   swp_rdata;
  logic               tbl_re, car_re;

  // Phases of a never-written entry read as zero
  assign car_ph = ph_vld_q[ch_q] ? ph_rdata[3*PW-1:2*PW] : '0;
  assign env_ph = ph_vld_q[ch_q] ? ph_rdata[2*PW-1:PW]   : '0;
  assign sw_ph  = ph_vld_q[ch_q] ? ph_rdata[PW-1:0]      : '0;

  // Sweep and envelope advance; carrier advance once the sweep word is back
  assign sw_new   = ch_fm ? sw_ph + PW'(fm_step_q[ch_q]) : sw_ph;
  assign env_new  = ch_am ? env_ph + PW'(am_step_q[ch_q]) : env_ph;
  assign car_new  = car_old_q + (ch_fm ? PW'(swp_rdata) : PW'(car_step_q[ch_q]));
  assign ph_wdata = {car_new, env_q, sw_q};
  assign gain_d   = ch_am ? env_rdata : SampleW'(EnvFull);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TBL_RD) begin
      car_old_q <= car_ph;
      env_q     <= env_new;
      sw_q      <= sw_new;
    end
    if (state_q == ST_CAR_RD) begin
      gain_q <= gain_d;
    end
  end

  dds_ram #(.Width(3*PW), .Depth(2)) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (ch_q),
    .wdata_i (ph_wdata),
    .re_i    (ph_re),
    .raddr_i (ch_q),
    .rdata_o (ph_rdata)
  );

  dds_ram #(.Width(SampleW), .Depth(2**(CW+1))) u_car_ram (
    .clk_i   (clk_i),
    .we_i    (car_we),
    .waddr_i ({in_ch, CW'(tbl_idx)}),
    .wdata_i (tbl_val[SampleW-1:0]),
    .re_i    (car_re),
    .raddr_i ({ch_q, wave_idx(car_new)}),
    .rdata_o (car_rdata)
  );

  dds_ram #(.Width(SampleW), .Depth(2**(CW+1))) u_env_ram (
    .clk_i   (clk_i),
    .we_i    (env_we),
    .waddr_i ({in_ch, CW'(tbl_idx)}),
    .wdata_i (tbl_val[SampleW-1:0]),
    .re_i    (tbl_re),
    .raddr_i ({ch_q, wave_idx(env_new)}),
    .rdata_o (env_rdata)
  );

  dds_ram #(.Width(StepW), .Depth(2**(SW+1))) u_swp_ram (
    .clk_i   (clk_i),
    .we_i    (swp_we),
    .waddr_i ({in_ch, SW'(tbl_idx)}),
    .wdata_i (tbl_val),
    .re_i    (tbl_re),
    .raddr_i ({ch_q, sweep_idx(sw_new)}),
    .rdata_o (swp_rdata)
  );

  dds_scale u_scale (
    .clk_i     (clk_i),
    .carrier_i (car_rdata),
    .env_i     (gain_q),
    .sample_o  (scaled)
  );

  // Per-channel samples and output register
  logic [SampleW-1:0] smp_q [2];
  logic               out_vld_q, out_vld_d;
  logic [23:0]        out_data_q;
  logic               out_load;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      smp_q[ch_q] <= ch_en ? scaled : SampleW'(MidCode);
    end
    if (out_load) begin
      out_data_q <= {smp_q[1], smp_q[0]};
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    ph_re     = 1'b0;
    ph_we     = 1'b0;
    tbl_re    = 1'b0;
    car_re    = 1'b0;
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_TICK)) begin
          ch_d    = 1'b0;
          state_d = ST_PH_RD;
        end
      end
      ST_PH_RD: begin
        ph_re   = 1'b1;
        state_d = ST_TBL_RD;
      end
      ST_TBL_RD: begin
        tbl_re  = 1'b1;
        state_d = ST_CAR_RD;
      end
      ST_CAR_RD: begin
        car_re  = 1'b1;
        ph_we   = ch_en;
        state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_P2;
      ST_P2:   state_d = ST_DIV;
      ST_DIV:  state_d = ST_FIN;
      ST_FIN: begin
        if (ch_q) begin
          state_d = ST_OUT;
        end else begin
          ch_d    = 1'b1;
          state_d = ST_PH_RD;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= 1'b0;
      out_vld_q <= 1'b0;
      ph_vld_q  <= '0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      out_vld_q <= out_vld_d;
      if (ph_we) begin
        ph_vld_q[ch_q] <= 1'b1;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_tbl_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (car_we || env_we || swp_we) |-> (state_q == ST_IDLE))
    else $error("table write outside idle");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && ch_en) |-> (scaled >= 12'd716 && scaled <= 12'd3378))
    else $error("scaled sample out of range");

  a_second_ch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && ch_q) |=> (state_q == ST_OUT))
    else $error("tick did not finish after second channel");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  a_ph_wr_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_we |-> (ch_en && state_q == ST_CAR_RD))
    else $error("phase written for disabled channel");

endmodule
